// File: src/tsba_pkg.sv
`timescale 1ns / 1ps
// Package for the typed slot bitmap allocator.
// Holds payload structs, request codes and sequencer states; no dependencies.
package tsba_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [1:0] var_type;
        logic [5:0] slot;
    } t_req;

    typedef struct packed {
        logic [5:0] slot_index;
        logic       full_res;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_HOLD
    } t_state;

endpackage

// File: src/tsba_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface used by the allocator's request and response channels.
// Payload type is a parameter; no package dependency.
interface tsba_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/typed_slot_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// Allocate: after the request is taken, the type's bitmap words (1..4 at defaults) are scanned
// one word per cycle through the bitmap memory and one encoder until a free bit is found.
// Free: read-modify-write of the slot's word. Out-of-range requests are answered from idle.
// A new request is taken the cycle after the response is registered.
// Reset (synchronous, i_rst_n low): a clearing pass writes all TYPE_COUNT*ceil(SLOTS_PER_TYPE/WORD_BITS)
// bitmap words (16 at defaults), freeing every slot but slot 0 of each type; no requests meanwhile.
module typed_slot_bitmap_allocator_top #(
    parameter int SLOTS_PER_TYPE = 64,
    parameter int WORD_BITS      = 16,
    parameter int TYPE_COUNT     = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsba_stream_if.sink   i_req,
    tsba_stream_if.source o_rsp
);
    import tsba_pkg::*;

    localparam int WORDS       = (SLOTS_PER_TYPE + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS = TYPE_COUNT * WORDS;
    localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WIDX_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BASE_RAW    = $clog2(SLOTS_PER_TYPE + WORD_BITS);
    localparam int BASE_W      = (BASE_RAW > 6) ? BASE_RAW : 7;
    localparam int LAST_BITS   = SLOTS_PER_TYPE - (WORDS - 1) * WORD_BITS;
    localparam int SLOT_SPAN   = (64 + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_WORDS  = (WORDS < SLOT_SPAN) ? WORDS : SLOT_SPAN;
    localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

    logic [WORD_BITS-1:0] mem [TOTAL_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [WIDX_W-1:0]    r_widx, n_widx;
    logic [BASE_W-1:0]    r_base, n_base;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [5:0]           r_slot, n_slot;
    t_rsp                 r_res, n_res;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_out_valid, n_out_valid;

    logic [ADDR_W-1:0]    rd_addr;
    logic                 we;
    logic [WORD_BITS-1:0] wd;
    logic                 out_free;
    logic                 type_ok;
    logic                 slot_ok;
    logic [WIDX_W-1:0]    f_widx;
    logic [BIT_W-1:0]     f_bit;
    logic [ADDR_W-1:0]    type_base;
    logic                 last_word;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BIT_W-1:0]     found_pos;
    logic [BASE_W-1:0]    found_slot;
    logic                 fin;
    t_rsp                 fin_res;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign type_ok     = 32'(i_req.data.var_type) < TYPE_COUNT;
    assign slot_ok     = 32'(i_req.data.slot) < SLOTS_PER_TYPE;
    assign type_base   = ADDR_W'(ADDR_W'(i_req.data.var_type) * ADDR_W'(WORDS));
    assign last_word   = (r_widx == WIDX_W'(WORDS - 1));
    assign free_bits   = ~r_rdata & (last_word ? LAST_MASK : {WORD_BITS{1'b1}});
    assign found_slot  = r_base + BASE_W'(found_pos);
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // word and bit of the slot to free
    always_comb begin
        f_widx = '0;
        f_bit  = '0;
        for (int k = 0; k < SLOT_WORDS; k++) begin
            if (32'(i_req.data.slot) >= k * WORD_BITS) begin
                f_widx = WIDX_W'(k);
                f_bit  = BIT_W'(32'(i_req.data.slot) - k * WORD_BITS);
            end
        end
    end

    // lowest free bit of the current word
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found     = 1'b1;
                found_pos = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_widx      = r_widx;
        n_base      = r_base;
        n_bit       = r_bit;
        n_slot      = r_slot;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid;
        rd_addr     = r_addr;
        we          = 1'b0;
        wd          = r_rdata;
        fin         = 1'b0;
        fin_res     = r_res;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                wd = (r_widx == '0) ? WORD_BITS'(1) : '0;
                n_addr = r_addr + 1'b1;
                n_widx = last_word ? '0 : r_widx + 1'b1;
                if (r_addr == ADDR_W'(TOTAL_WORDS - 1)) begin
                    n_addr  = '0;
                    n_widx  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.data.req_type == REQ_ALLOC) begin
                        if (type_ok) begin
                            rd_addr = type_base;
                            n_addr  = type_base;
                            n_widx  = '0;
                            n_base  = '0;
                            n_state = ST_SCAN;
                        end else begin
                            fin     = 1'b1;
                            fin_res = '{slot_index: 6'd0, full_res: 1'b1};
                        end
                    end else begin
                        if (type_ok && slot_ok) begin
                            rd_addr = type_base + ADDR_W'(f_widx);
                            n_addr  = type_base + ADDR_W'(f_widx);
                            n_bit   = f_bit;
                            n_slot  = i_req.data.slot;
                            n_state = ST_FREE;
                        end else begin
                            fin     = 1'b1;
                            fin_res = '{slot_index: i_req.data.slot, full_res: 1'b0};
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (found) begin
                    we      = 1'b1;
                    wd      = r_rdata | (WORD_BITS'(1) << found_pos);
                    fin     = 1'b1;
                    fin_res = '{slot_index: found_slot[5:0], full_res: 1'b0};
                end else if (last_word) begin
                    fin     = 1'b1;
                    fin_res = '{slot_index: 6'd0, full_res: 1'b1};
                end else begin
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_widx  = r_widx + 1'b1;
                    n_base  = r_base + BASE_W'(WORD_BITS);
                end
            end
            ST_FREE: begin
                we      = 1'b1;
                wd      = r_rdata & ~(WORD_BITS'(1) << r_bit);
                fin     = 1'b1;
                fin_res = '{slot_index: r_slot, full_res: 1'b0};
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_rsp       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_rsp       = fin_res;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = ST_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_addr] <= wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_bit  <= n_bit;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_rsp  <= n_rsp;
    end

endmodule
